// ----- hw/rtl/ptd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int LINK_W    = $clog2(MAX_TASKS + 1);
   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_TASKS);

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] RES_RUN  = 2'd0;
   localparam logic [1:0] RES_OK   = 2'd1;
   localparam logic [1:0] RES_FULL = 2'd2;

   localparam logic [1:0] LIST_INT  = 2'd0;
   localparam logic [1:0] LIST_MAIN = 2'd1;
   localparam logic [1:0] LIST_IDLE = 2'd2;

   localparam logic CSR_TICK_PERIOD = 1'b0;
   localparam logic CSR_MAIN_DIV    = 1'b1;

   localparam logic [19:0] TICK_PERIOD_RESET = 20'd1000;
   localparam logic [15:0] MAIN_DIV_RESET    = 16'd1;

   typedef struct packed {
      logic [31:0]       period;
      logic [31:0]       phase;
      logic [31:0]       prio;
      logic [3:0]        owner;
      logic [LINK_W-1:0] link;
   } slot_rec_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_C_START,
      S_C_MOD,
      S_C_DIVP,
      S_C_DIVQ,
      S_INS_HEAD,
      S_INS_DATA,
      S_INS_WNEW,
      S_INS_WPREV,
      S_W_HEAD,
      S_W_DATA,
      S_W_DIV,
      S_W_EMIT,
      S_W_END,
      S_T_MOD,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/periodic_task_dispatcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A create passes the entries in its list; a tick due-checks each interrupt entry; a poll
// due-checks each main entry when a main tick is pending and then emits each idle entry.
// All modulo and divide work runs on one shared restoring divider, one quotient bit per
// cycle. One item at a time; the next beat is taken once the previous done beat is in the
// output register.
// Reset (synchronous): lists empty, counters and pending flag cleared, registers to 1000/1.
module periodic_task_dispatcher (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [3:0] task_id, [4] task_kind, [36:5] period_us, [68:37] phase_us,
   // [100:69] priority_req, [103:101] zero
   input  wire logic [103:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [3:0] run_id, [35:4] system_tick, [39:36] zero
   output logic [39:0]       rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [19:0]  csr_wdata
);
   import ptd_pkg::*;

   state_type state_ff, state_in;

   logic [3:0]  id_ff, id_in;
   logic        kind_ff, kind_in;
   logic [31:0] per_ff, per_in;
   logic [31:0] pha_ff, pha_in;
   logic [31:0] pri_ff, pri_in;
   logic [1:0]  list_ff, list_in;
   logic [35:0] ti_ff, ti_in;
   logic        check_ff, check_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  code_ff, code_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   slot_rec_type      prev_rec_ff, prev_rec_in;
   logic [LINK_W-1:0] heads_ff [3];
   logic [LINK_W-1:0] heads_in [3];
   logic [LINK_W-1:0] used_ff, used_in;
   logic [31:0] iticks_ff, iticks_in;
   logic [31:0] mticks_ff, mticks_in;
   logic        pending_ff, pending_in;
   logic [19:0] tick_cfg_ff;
   logic [15:0] mdiv_cfg_ff;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [3:0]  out_id_ff, out_id_in;
   logic [31:0] out_tick_ff, out_tick_in;
   logic        out_last_ff, out_last_in;
   logic        out_free;

   // slot memory
   slot_rec_type mem [MAX_TASKS];
   slot_rec_type rd_ff;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_raddr, mem_waddr;
   slot_rec_type     mem_wdata;

   // shared divider
   logic        div_start;
   logic [31:0] div_a;
   logic [35:0] div_b;
   logic        div_busy_ff;
   logic [4:0]  div_cnt_ff;
   logic [31:0] div_n_ff, div_q_ff;
   logic [35:0] div_d_ff, div_r_ff;
   logic [36:0] div_t;

   logic [19:0] tick_eff;
   logic [15:0] mdiv_eff;

   assign tick_eff = (tick_cfg_ff == '0) ? 20'd1 : tick_cfg_ff;
   assign mdiv_eff = (mdiv_cfg_ff == '0) ? 16'd1 : mdiv_cfg_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_tick_ff, out_id_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   // restoring divide, one bit a cycle
   assign div_t = {div_r_ff, div_n_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (div_cnt_ff == 5'd31) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_n_ff <= div_a;
         div_d_ff <= div_b;
         div_r_ff <= '0;
         div_q_ff <= '0;
      end else if (div_busy_ff) begin
         div_n_ff <= {div_n_ff[30:0], 1'b0};
         if (div_t >= {1'b0, div_d_ff}) begin
            div_r_ff <= 36'(div_t - {1'b0, div_d_ff});
            div_q_ff <= {div_q_ff[30:0], 1'b1};
         end else begin
            div_r_ff <= div_t[35:0];
            div_q_ff <= {div_q_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_cfg_ff <= TICK_PERIOD_RESET;
         mdiv_cfg_ff <= MAIN_DIV_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TICK_PERIOD: tick_cfg_ff <= csr_wdata;
            CSR_MAIN_DIV:    mdiv_cfg_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heads_ff[0]  <= LINK_END;
         heads_ff[1]  <= LINK_END;
         heads_ff[2]  <= LINK_END;
         used_ff      <= '0;
         iticks_ff    <= '0;
         mticks_ff    <= '0;
         pending_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heads_ff     <= heads_in;
         used_ff      <= used_in;
         iticks_ff    <= iticks_in;
         mticks_ff    <= mticks_in;
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
      id_ff       <= id_in;
      kind_ff     <= kind_in;
      per_ff      <= per_in;
      pha_ff      <= pha_in;
      pri_ff      <= pri_in;
      list_ff     <= list_in;
      ti_ff       <= ti_in;
      check_ff    <= check_in;
      count_ff    <= count_in;
      code_ff     <= code_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_rec_ff <= prev_rec_in;
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_tick_ff <= out_tick_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      kind_in      = kind_ff;
      per_in       = per_ff;
      pha_in       = pha_ff;
      pri_in       = pri_ff;
      list_in      = list_ff;
      ti_in        = ti_ff;
      check_in     = check_ff;
      count_in     = count_ff;
      code_in      = code_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_rec_in  = prev_rec_ff;
      heads_in     = heads_ff;
      used_in      = used_ff;
      iticks_in    = iticks_ff;
      mticks_in    = mticks_ff;
      pending_in   = pending_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_tick_in  = out_tick_ff;
      out_last_in  = out_last_ff;
      mem_re       = 1'b0;
      mem_raddr    = cur_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = used_ff[IDX_W-1:0];
      mem_wdata    = '{period: per_ff, phase: pha_ff, prio: pri_ff, owner: id_ff,
                       link: cur_ff};
      div_start    = 1'b0;
      div_a        = count_ff;
      div_b        = {4'b0, rd_ff.period};

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               id_in   = req_tdata[3:0];
               kind_in = req_tdata[4];
               per_in  = req_tdata[36:5];
               pha_in  = req_tdata[68:37];
               pri_in  = req_tdata[100:69];
               code_in = RES_OK;
               unique case (req_tuser)
                  OP_CREATE: state_in = S_C_START;
                  OP_TICK: begin
                     iticks_in = iticks_ff + 32'd1;
                     count_in  = iticks_ff + 32'd1;
                     list_in   = LIST_INT;
                     check_in  = 1'b1;
                     state_in  = S_W_HEAD;
                  end
                  OP_POLL: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        count_in   = mticks_ff;
                        list_in    = LIST_MAIN;
                        check_in   = 1'b1;
                     end else begin
                        list_in  = LIST_IDLE;
                        check_in = 1'b0;
                     end
                     state_in = S_W_HEAD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_C_START: begin
            if (used_ff == LINK_END) begin
               code_in  = RES_FULL;
               state_in = S_DONE;
            end else if (per_ff == '0) begin
               list_in  = LIST_IDLE;
               pha_in   = '0;
               state_in = S_INS_HEAD;
            end else begin
               list_in   = kind_ff ? LIST_MAIN : LIST_INT;
               ti_in     = kind_ff ? 36'(tick_eff) * 36'(mdiv_eff) : 36'(tick_eff);
               div_start = 1'b1;
               div_a     = pha_ff;
               div_b     = {4'b0, per_ff};
               state_in  = S_C_MOD;
            end
         end

         S_C_MOD: begin
            if (!div_busy_ff) begin
               pha_in    = div_r_ff[31:0];
               div_start = 1'b1;
               div_a     = per_ff;
               div_b     = ti_ff;
               state_in  = S_C_DIVP;
            end
         end

         S_C_DIVP: begin
            if (!div_busy_ff) begin
               per_in    = div_q_ff;
               div_start = 1'b1;
               div_a     = pha_ff;
               div_b     = ti_ff;
               state_in  = S_C_DIVQ;
            end
         end

         S_C_DIVQ: begin
            if (!div_busy_ff) begin
               // period shorter than one tick: run every tick
               if (per_ff == '0) begin
                  per_in = 32'd1;
                  pha_in = '0;
               end else begin
                  pha_in = div_q_ff;
               end
               state_in = S_INS_HEAD;
            end
         end

         S_INS_HEAD: begin
            cur_in    = heads_ff[list_ff];
            prev_in   = LINK_END;
            mem_raddr = heads_ff[list_ff][IDX_W-1:0];
            if (heads_ff[list_ff] == LINK_END) begin
               state_in = S_INS_WNEW;
            end else begin
               mem_re   = 1'b1;
               state_in = S_INS_DATA;
            end
         end

         S_INS_DATA: begin
            // pass entries of lower or equal priority
            if (!(pri_ff < rd_ff.prio)) begin
               prev_in     = cur_ff;
               prev_rec_in = rd_ff;
               cur_in      = rd_ff.link;
               mem_raddr   = rd_ff.link[IDX_W-1:0];
               if (rd_ff.link == LINK_END) begin
                  state_in = S_INS_WNEW;
               end else begin
                  mem_re = 1'b1;
               end
            end else begin
               state_in = S_INS_WNEW;
            end
         end

         S_INS_WNEW: begin
            mem_we = 1'b1;
            if (prev_ff == LINK_END) begin
               heads_in[list_ff] = used_ff;
               used_in           = used_ff + 1'b1;
               state_in          = S_DONE;
            end else begin
               state_in = S_INS_WPREV;
            end
         end

         S_INS_WPREV: begin
            mem_we         = 1'b1;
            mem_waddr      = prev_ff[IDX_W-1:0];
            mem_wdata      = prev_rec_ff;
            mem_wdata.link = used_ff;
            used_in        = used_ff + 1'b1;
            state_in       = S_DONE;
         end

         S_W_HEAD: begin
            cur_in    = heads_ff[list_ff];
            mem_raddr = heads_ff[list_ff][IDX_W-1:0];
            if (heads_ff[list_ff] == LINK_END) begin
               state_in = S_W_END;
            end else begin
               mem_re   = 1'b1;
               state_in = S_W_DATA;
            end
         end

         S_W_DATA: begin
            if (!check_ff) begin
               state_in = S_W_EMIT;
            end else if (rd_ff.period != '0) begin
               div_start = 1'b1;
               state_in  = S_W_DIV;
            end else begin
               cur_in    = rd_ff.link;
               mem_raddr = rd_ff.link[IDX_W-1:0];
               if (rd_ff.link == LINK_END) begin
                  state_in = S_W_END;
               end else begin
                  mem_re = 1'b1;
               end
            end
         end

         S_W_DIV: begin
            if (!div_busy_ff) begin
               if (div_r_ff == {4'b0, rd_ff.phase}) begin
                  state_in = S_W_EMIT;
               end else begin
                  cur_in    = rd_ff.link;
                  mem_raddr = rd_ff.link[IDX_W-1:0];
                  if (rd_ff.link == LINK_END) begin
                     state_in = S_W_END;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = S_W_DATA;
                  end
               end
            end
         end

         S_W_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RES_RUN;
               out_id_in    = rd_ff.owner;
               out_tick_in  = '0;
               out_last_in  = 1'b0;
               cur_in       = rd_ff.link;
               mem_raddr    = rd_ff.link[IDX_W-1:0];
               if (rd_ff.link == LINK_END) begin
                  state_in = S_W_END;
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_W_DATA;
               end
            end
         end

         S_W_END: begin
            unique case (list_ff)
               LIST_INT: begin
                  div_start = 1'b1;
                  div_a     = count_ff;
                  div_b     = 36'(mdiv_eff);
                  state_in  = S_T_MOD;
               end
               LIST_MAIN: begin
                  list_in  = LIST_IDLE;
                  check_in = 1'b0;
                  state_in = S_W_HEAD;
               end
               default: state_in = S_DONE;
            endcase
         end

         S_T_MOD: begin
            if (!div_busy_ff) begin
               if (div_r_ff == '0) begin
                  pending_in = 1'b1;
                  mticks_in  = mticks_ff + 32'd1;
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = code_ff;
               out_id_in    = '0;
               out_tick_in  = mticks_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LINK_END)
      else $error("slot count beyond table size");

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy_ff)
      else $error("divider restarted while busy");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy_ff)
      else $error("divider busy while taking a beat");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff != S_IDLE)
      else $error("accepted beat not processed");

   a_pending_source: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> $past(state_ff) == S_T_MOD)
      else $error("pending flag raised outside tick step");

endmodule

`default_nettype wire
